### sv/kse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kse_pkg;

  localparam int KEY_W  = 9;
  localparam int BYTE_W = 8;

  // Output queue geometry: two slots must be free before a request is decoded.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Escape syntax characters.
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_DASH   = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3f;
  localparam logic [BYTE_W-1:0] CH_UC     = 8'h43;
  localparam logic [BYTE_W-1:0] CH_LC     = 8'h63;
  localparam logic [BYTE_W-1:0] CH_UM     = 8'h4d;
  localparam logic [BYTE_W-1:0] CH_LM     = 8'h6d;
  localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
  localparam logic [BYTE_W-1:0] CH_E      = 8'h65;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6e;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_A      = 8'h61;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_V      = 8'h76;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_7      = 8'h37;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h66;
  localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;

  // Key codes produced by escapes.
  localparam logic [KEY_W-1:0] KEY_ESC = 9'h01b;
  localparam logic [KEY_W-1:0] KEY_DEL = 9'h07f;
  localparam logic [KEY_W-1:0] KEY_NL  = 9'h00a;
  localparam logic [KEY_W-1:0] KEY_CR  = 9'h00d;
  localparam logic [KEY_W-1:0] KEY_TAB = 9'h009;
  localparam logic [KEY_W-1:0] KEY_BEL = 9'h007;
  localparam logic [KEY_W-1:0] KEY_BS  = 9'h008;
  localparam logic [KEY_W-1:0] KEY_FF  = 9'h00c;
  localparam logic [KEY_W-1:0] KEY_VT  = 9'h00b;
  localparam logic [BYTE_W-1:0] CTRL_MASK = 8'h1f;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic             code_valid;
    logic             seq_end;
    logic             last;
  } kse_res_t;

  typedef struct packed {
    logic [1:0] n;
    kse_res_t   r0;
    kse_res_t   r1;
  } kse_pair_t;

endpackage
`default_nettype wire

### sv/kse_decode.sv
`timescale 1ns / 1ps
`default_nettype none
module kse_decode (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic                      action,
  input  wire logic [kse_pkg::BYTE_W-1:0] char_byte,
  output kse_pkg::kse_pair_t             pair
);
  import kse_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_BSLASH = 3'd1,
    M_CSEEN  = 3'd2,
    M_CTRL   = 3'd3,
    M_MSEEN  = 3'd4,
    M_HEX    = 3'd5,
    M_OCT    = 3'd6
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic              upper_c_r, upper_c_nxt;
  logic [1:0]        dcount_r, dcount_nxt;
  logic [KEY_W-1:0]  dvalue_r, dvalue_nxt;

  logic              hex_ok, oct_ok, is_dash, is_bslash;
  logic [3:0]        hex_d;
  logic [KEY_W-1:0]  hex_acc, oct_acc, cseen_code, ctrl_code, byte_code;
  logic [1:0]        dcount_inc;

  logic              lead_v, lead_cv, lead_end, do_plain, tail_v;
  logic [KEY_W-1:0]  lead_code;
  kse_res_t          lead, tail;

  assign is_dash    = (char_byte == CH_DASH);
  assign is_bslash  = (char_byte == CH_BSLASH);
  assign byte_code  = KEY_W'(char_byte);
  assign cseen_code = upper_c_r ? KEY_W'(CH_UC) : KEY_W'(CH_LC);
  // Upper-casing only clears bit 5, which the 5-bit mask drops anyway.
  assign ctrl_code  = (char_byte == CH_QMARK) ? KEY_DEL : KEY_W'(char_byte & CTRL_MASK);
  assign oct_ok     = (char_byte >= CH_0) && (char_byte <= CH_7);
  assign dcount_inc = dcount_r + 2'd1;
  assign hex_acc    = {dvalue_r[4:0], hex_d};
  assign oct_acc    = {dvalue_r[5:0], char_byte[2:0]};

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if ((char_byte >= CH_0) && (char_byte <= CH_9)) begin
      hex_d = 4'(char_byte - CH_0);
    end else if ((char_byte >= CH_LA) && (char_byte <= CH_LF)) begin
      hex_d = 4'(char_byte - CH_LA + 8'd10);
    end else if ((char_byte >= CH_UA) && (char_byte <= CH_UF)) begin
      hex_d = 4'(char_byte - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    upper_c_nxt = upper_c_r;
    dcount_nxt  = dcount_r;
    dvalue_nxt  = dvalue_r;
    lead_v      = 1'b0;
    lead_cv     = 1'b1;
    lead_end    = 1'b0;
    lead_code   = '0;
    do_plain    = 1'b0;

    if (action) begin
      lead_v   = 1'b1;
      lead_end = 1'b1;
      unique case (mode_r)
        M_CSEEN:      lead_code = cseen_code;
        M_HEX, M_OCT: lead_code = dvalue_r;
        default: begin
          lead_cv = 1'b0;
        end
      endcase
      mode_nxt    = M_NORMAL;
      upper_c_nxt = 1'b0;
      dcount_nxt  = '0;
      dvalue_nxt  = '0;
    end else begin
      unique case (mode_r)
        M_BSLASH: begin
          mode_nxt = M_NORMAL;
          unique case (char_byte) inside
            CH_UC, CH_LC: begin
              upper_c_nxt = (char_byte == CH_UC);
              mode_nxt    = M_CSEEN;
            end
            CH_UM, CH_LM: mode_nxt = M_MSEEN;
            CH_E: begin lead_v = 1'b1; lead_code = KEY_ESC; end
            CH_N: begin lead_v = 1'b1; lead_code = KEY_NL;  end
            CH_R: begin lead_v = 1'b1; lead_code = KEY_CR;  end
            CH_T: begin lead_v = 1'b1; lead_code = KEY_TAB; end
            CH_A: begin lead_v = 1'b1; lead_code = KEY_BEL; end
            CH_B: begin lead_v = 1'b1; lead_code = KEY_BS;  end
            CH_F: begin lead_v = 1'b1; lead_code = KEY_FF;  end
            CH_V: begin lead_v = 1'b1; lead_code = KEY_VT;  end
            CH_X: begin
              dcount_nxt = '0;
              dvalue_nxt = '0;
              mode_nxt   = M_HEX;
            end
            [CH_0:CH_7]: begin
              dcount_nxt = 2'd1;
              dvalue_nxt = KEY_W'(char_byte[2:0]);
              mode_nxt   = M_OCT;
            end
            default: begin
              lead_v    = 1'b1;
              lead_code = byte_code;
            end
          endcase
        end
        M_CSEEN: begin
          if (is_dash) begin
            mode_nxt = M_CTRL;
          end else begin
            lead_v    = 1'b1;
            lead_code = cseen_code;
            do_plain  = 1'b1;
          end
        end
        M_CTRL: begin
          lead_v    = 1'b1;
          lead_code = ctrl_code;
          mode_nxt  = M_NORMAL;
        end
        M_MSEEN: begin
          if (is_dash) begin
            lead_v    = 1'b1;
            lead_code = KEY_ESC;
            mode_nxt  = M_NORMAL;
          end else begin
            do_plain = 1'b1;
          end
        end
        M_HEX: begin
          if (hex_ok) begin
            dvalue_nxt = hex_acc;
            dcount_nxt = dcount_inc;
            if (dcount_inc >= 2'd2) begin
              lead_v    = 1'b1;
              lead_code = hex_acc;
              mode_nxt  = M_NORMAL;
            end
          end else begin
            lead_v    = 1'b1;
            lead_code = dvalue_r;
            do_plain  = 1'b1;
          end
        end
        M_OCT: begin
          if (oct_ok) begin
            dvalue_nxt = oct_acc;
            dcount_nxt = dcount_inc;
            if (dcount_inc >= 2'd3) begin
              lead_v    = 1'b1;
              lead_code = oct_acc;
              mode_nxt  = M_NORMAL;
            end
          end else begin
            lead_v    = 1'b1;
            lead_code = dvalue_r;
            do_plain  = 1'b1;
          end
        end
        default: do_plain = 1'b1;
      endcase
    end

    // Plain byte handling: a backslash opens an escape, anything else passes.
    tail_v = do_plain && !is_bslash;
    if (do_plain) begin
      mode_nxt = is_bslash ? M_BSLASH : M_NORMAL;
    end
  end

  always_comb begin
    lead = '{key_code: lead_code, code_valid: lead_cv, seq_end: lead_end, last: 1'b0};
    tail = '{key_code: byte_code, code_valid: 1'b1, seq_end: 1'b0, last: 1'b0};
    pair.n  = {1'b0, lead_v} + {1'b0, tail_v};
    pair.r0 = lead_v ? lead : tail;
    pair.r1 = tail;
    pair.r0.last = (pair.n == 2'd1);
    pair.r1.last = (pair.n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_NORMAL;
      upper_c_r <= 1'b0;
      dcount_r  <= '0;
      dvalue_r  <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      upper_c_r <= upper_c_nxt;
      dcount_r  <= dcount_nxt;
      dvalue_r  <= dvalue_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && action) |=> (mode_r == M_NORMAL && dcount_r == 2'd0 && dvalue_r == '0))
    else $error("end request did not return the decoder to idle");

  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (pair.n == 2'd2) |-> (!action && (mode_r == M_CSEEN || mode_r == M_HEX
                                      || mode_r == M_OCT)))
    else $error("two results from a mode that cannot flush");

endmodule
`default_nettype wire

### sv/kse_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module kse_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire kse_pkg::kse_pair_t pair,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output kse_pkg::kse_res_t       head
);
  import kse_pkg::*;

  kse_res_t             q_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [QCNT_W-1:0]    cnt_r, cnt_nxt, push_n;
  logic                 pop;

  assign room      = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign head      = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = push ? QCNT_W'(pair.n) : '0;
  assign wr_ptr_p1 = QPTR_W'(wr_ptr_r + 1'b1);

  always_comb begin
    cnt_nxt    = QCNT_W'(cnt_r + push_n - QCNT_W'(pop));
    wr_ptr_nxt = QPTR_W'(wr_ptr_r + push_n[QPTR_W-1:0]);
    rd_ptr_nxt = QPTR_W'(rd_ptr_r + QPTR_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pair.n != 2'd0) begin
      q_r[wr_ptr_r] <= pair.r0;
    end
    if (push && pair.n == 2'd2) begin
      q_r[wr_ptr_p1] <= pair.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("results pushed without two free slots");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == QPTR_W'(rd_ptr_r + cnt_r[QPTR_W-1:0]))
    else $error("queue pointers disagree with fill count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

### sv/key_sequence_escape_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted request is held in the input register, then decoded and queued
//   once the result queue has two free slots; its first result then shows on out_.
// Throughput: one request per cycle while the queue has room; a request that flushes
//   a pending escape can give two results, and the single-result output port then sets the pace.
// Reset: synchronous, active low; clears the escape state, input valid flag and queue count and pointers.
module key_sequence_escape_decoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_action,
  input  wire logic [kse_pkg::BYTE_W-1:0]  in_char_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [kse_pkg::KEY_W-1:0]        out_key_code,
  output logic                             out_code_valid,
  output logic                             out_seq_end,
  output logic                             out_last
);
  import kse_pkg::*;

  // Input register: holds one request until the queue can take its results.
  logic                 in_vld_r, in_vld_nxt;
  logic                 in_action_r;
  logic [BYTE_W-1:0]    in_byte_r;
  logic                 room, adv;
  kse_pair_t            pair;
  kse_res_t             head;

  // Advance the held request into the decoder and queue once two slots are free.
  assign adv      = in_vld_r && room;
  assign in_stall = in_vld_r && !room;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Payload needs no reset; load only on an accepted request.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action_r <= in_action;
      in_byte_r   <= in_char_byte;
    end
  end

  // Escape state machine: decodes the held byte against the pending escape.
  kse_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .action    (in_action_r),
    .char_byte (in_byte_r),
    .pair      (pair)
  );

  // Result queue: drains one result per cycle toward the consumer while out_stall is low.
  kse_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .pair      (pair),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_key_code   = head.key_code;
  assign out_code_valid = head.code_valid;
  assign out_seq_end    = head.seq_end;
  assign out_last       = head.last;

endmodule
`default_nettype wire
